// ----- rtl/pkvfp_pkg.sv -----
`timescale 1ns / 1ps
package pkvfp_pkg;

  localparam int unsigned KEY_NUM     = 18;
  localparam int unsigned KEY_MAX_LEN = 11;

  // key names right-aligned, first character in the highest used byte
  localparam logic [8*KEY_MAX_LEN-1:0] KEY_TEXT [KEY_NUM] = '{
    "opCode=", "respCode=", {"kr", "agId="}, "gameId=", "guideId=",
    {"peb", "bleId="}, "latitude=", "longitude=", "numPlayers=", "numClaimed=",
    {"numKr", "ags="}, "statusReq=", "player=", "team=", "hint=", "clue=",
    "secret=", "text="
  };

  localparam logic [3:0] KEY_LEN [KEY_NUM] = '{
    4'd7, 4'd9, 4'd7, 4'd7, 4'd8, 4'd9, 4'd9, 4'd10, 4'd11, 4'd11, 4'd9,
    4'd10, 4'd7, 4'd5, 4'd5, 4'd5, 4'd7, 4'd5
  };

  localparam logic [7:0] ACK_TEXT  [4] = '{8'h41, 8'h43, 8'h4B, 8'h00};
  localparam logic [7:0] NACK_TEXT [4] = '{8'h4E, 8'h41, 8'h43, 8'h4B};

  localparam logic [7:0] SEP_CHAR = 8'h7C;

  typedef enum logic [2:0] {
    PH_KEY   = 3'b001,
    PH_VALUE = 3'b010,
    PH_HALT  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_INVALID = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef struct packed {
    logic                 value_valid;
    logic [7:0]           value_byte;
    logic [4:0]           field_id;
    logic                 field_open;
    logic                 done_res;
    status_e              status;
    logic [KEY_NUM-1:0]   present_mask;
  } result_t;

  function automatic logic [7:0] key_char(input int unsigned idx, input logic [3:0] pos);
    logic [3:0]               off;
    logic [8*KEY_MAX_LEN-1:0] w;
    off = KEY_LEN[idx] - 4'd1 - pos;
    w   = KEY_TEXT[idx] >> {off, 3'b000};
    return w[7:0];
  endfunction

endpackage

// ----- rtl/pipe_key_value_field_parser_top.sv -----
`timescale 1ns / 1ps
// a result is registered when its item is accepted and is offered once older results are taken
// throughput: one item per cycle while the result buffer is not full; all matching for a
// byte is done between the parser state registers and a two-entry result buffer
// reset: parser returns to start of message, result buffer empties
// the parser state also returns to start of message after every last item
module pipe_key_value_field_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       value_valid_o,
  output logic [7:0] value_byte_o,
  output logic [4:0] field_id_o,
  output logic       field_open_o,
  output logic       done_res_o,
  output logic [1:0] status_o,
  output logic [pkvfp_pkg::KEY_NUM-1:0] present_mask_o
);
  import pkvfp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [2:0]         prefix_pos_q, prefix_pos_d;
  logic [1:0]         ack_cand_q, ack_cand_d;
  logic [KEY_NUM-1:0] key_cand_q, key_cand_d;
  logic [3:0]         key_pos_q, key_pos_d;
  logic [4:0]         cur_field_q, cur_field_d;
  logic [KEY_NUM-1:0] seen_q, seen_d;
  status_e            err_q, err_d;

  result_t            res;
  result_t            slot_q [2];
  logic [1:0]         cnt_q;
  logic               push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = out_valid_o & out_ready_i;

  always_comb begin
    logic [1:0]         na;
    logic               ack_hit;
    logic [KEY_NUM-1:0] nc;
    logic               hit;
    logic [4:0]         hit_idx;

    phase_d      = phase_q;
    prefix_pos_d = prefix_pos_q;
    ack_cand_d   = ack_cand_q;
    key_cand_d   = key_cand_q;
    key_pos_d    = key_pos_q;
    cur_field_d  = cur_field_q;
    seen_d       = seen_q;
    err_d        = err_q;
    res          = '0;
    na           = '0;
    ack_hit      = 1'b0;
    nc           = '0;
    hit          = 1'b0;
    hit_idx      = '0;

    // message prefix check for ACK / NACK
    if (prefix_pos_q < 3'd4 && ack_cand_q != 2'b00) begin
      if (ack_cand_q[0] && prefix_pos_q < 3'd3 &&
          data_byte_i == ACK_TEXT[prefix_pos_q[1:0]]) na[0] = 1'b1;
      if (ack_cand_q[1] && data_byte_i == NACK_TEXT[prefix_pos_q[1:0]]) na[1] = 1'b1;
      ack_cand_d = na;
      ack_hit    = (na[0] && prefix_pos_q == 3'd2) || (na[1] && prefix_pos_q == 3'd3);
    end
    if (prefix_pos_q < 3'd4) prefix_pos_d = prefix_pos_q + 3'd1;

    // parallel compare against every key name still in the running
    for (int unsigned k = 0; k < KEY_NUM; k++) begin
      if (key_cand_q[k] && key_pos_q < KEY_LEN[k] &&
          data_byte_i == key_char(k, key_pos_q)) begin
        nc[k] = 1'b1;
        if (key_pos_q + 4'd1 == KEY_LEN[k]) begin
          hit     = 1'b1;
          hit_idx = 5'(k);
        end
      end
    end

    if (ack_hit) begin
      seen_d  = '0;
      err_d   = ST_IGNORED;
      phase_d = PH_HALT;
    end else if (phase_q != PH_HALT) begin
      if (data_byte_i == 8'h00) begin
        if (phase_q == PH_KEY && key_pos_q != 4'd0) err_d = ST_INVALID;
        phase_d = PH_HALT;
      end else if (phase_q == PH_VALUE) begin
        if (data_byte_i == SEP_CHAR) begin
          phase_d    = PH_KEY;
          key_cand_d = '1;
          key_pos_d  = '0;
        end else begin
          res.value_valid = 1'b1;
          res.value_byte  = data_byte_i;
          res.field_id    = cur_field_q;
        end
      end else if (data_byte_i == SEP_CHAR) begin
        // runs of separators collapse, a cut-off key is invalid
        if (key_pos_q != 4'd0) begin
          err_d   = ST_INVALID;
          phase_d = PH_HALT;
        end
      end else begin
        key_cand_d = nc;
        if (nc == '0) begin
          err_d   = ST_INVALID;
          phase_d = PH_HALT;
        end else begin
          key_pos_d = key_pos_q + 4'd1;
          if (hit) begin
            if (seen_q[hit_idx]) begin
              err_d   = ST_DUP;
              phase_d = PH_HALT;
            end else begin
              seen_d[hit_idx] = 1'b1;
              cur_field_d     = hit_idx;
              phase_d         = PH_VALUE;
              res.field_open  = 1'b1;
              res.field_id    = hit_idx;
            end
          end
        end
      end
    end

    if (last_i) begin
      if (phase_d == PH_KEY && key_pos_d != 4'd0) err_d = ST_INVALID;
      res.done_res     = 1'b1;
      res.status       = err_d;
      res.present_mask = seen_d;
      phase_d      = PH_KEY;
      prefix_pos_d = '0;
      ack_cand_d   = 2'b11;
      key_cand_d   = '1;
      key_pos_d    = '0;
      cur_field_d  = '0;
      seen_d       = '0;
      err_d        = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_KEY;
      prefix_pos_q <= '0;
      ack_cand_q   <= 2'b11;
      key_cand_q   <= '1;
      key_pos_q    <= '0;
      cur_field_q  <= '0;
      seen_q       <= '0;
      err_q        <= ST_OK;
    end else if (push) begin
      phase_q      <= phase_d;
      prefix_pos_q <= prefix_pos_d;
      ack_cand_q   <= ack_cand_d;
      key_cand_q   <= key_cand_d;
      key_pos_q    <= key_pos_d;
      cur_field_q  <= cur_field_d;
      seen_q       <= seen_d;
      err_q        <= err_d;
    end
  end

  // two-entry result buffer, slot 0 is the head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !push) begin
      slot_q[0] <= slot_q[1];
    end else if (push && !pop) begin
      if (cnt_q == 2'd0) slot_q[0] <= res;
      else slot_q[1] <= res;
    end else if (push && pop) begin
      if (cnt_q == 2'd1) begin
        slot_q[0] <= res;
      end else begin
        slot_q[0] <= slot_q[1];
        slot_q[1] <= res;
      end
    end
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign value_valid_o  = slot_q[0].value_valid;
  assign value_byte_o   = slot_q[0].value_byte;
  assign field_id_o     = slot_q[0].field_id;
  assign field_open_o   = slot_q[0].field_open;
  assign done_res_o     = slot_q[0].done_res;
  assign status_o       = slot_q[0].status;
  assign present_mask_o = slot_q[0].present_mask;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_msg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && last_i |=> seen_q == '0 && key_pos_q == 4'd0 && err_q == ST_OK)
    else $error("parser state not cleared after last item");

  a_open_vs_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_open_o |-> !value_valid_o && field_id_o < 5'(KEY_NUM))
    else $error("field open carries a value byte or bad id");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ST_OK && present_mask_o == '0)
    else $error("status or mask outside final item");

  a_value_after_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.value_valid |-> phase_q == PH_VALUE && res.field_id == cur_field_q)
    else $error("value byte outside value phase");

endmodule
